>>> rtl/adfb_pkg.sv
// adfb_pkg: shared constants, register indexes and sideband types of the disc shader
// used by adfb_sqrt, adfb_blend and antialiased_disc_fill_blend_core
package adfb_pkg;

   localparam int COORD_BITS_DEF     = 12;
   localparam int SQRT_FRAC_BITS_DEF = 8;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int PIXEL_BITS     = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_RADIUS,
      CSR_FILL_COLOR
   } csr_index_type;

   localparam logic [7:0] ALPHA_MAX = 8'hFF;

   // floor(x / 255) = (x * DIV255_MUL) >> DIV255_SHIFT for x < 2**24
   localparam logic [24:0] DIV255_MUL   = 25'd16843010;
   localparam int          DIV255_SHIFT = 32;

   // width of a channel numerator before the divide by the result alpha
   localparam int NUM_BITS = 17;

   typedef struct packed {
      logic                  in_disc;
      logic                  band;
      logic [PIXEL_BITS-1:0] dst;
   } shade_side_type;

   typedef struct packed {
      logic                  touched;
      logic [PIXEL_BITS-1:0] dst;
      logic [PIXEL_BITS-1:0] src;
   } blend_side_type;

   function automatic logic [7:0] sat8(input logic [NUM_BITS-1:0] v);
      logic [7:0] r;
      r = (v > NUM_BITS'(ALPHA_MAX)) ? ALPHA_MAX : v[7:0];
      return r;
   endfunction

endpackage

>>> rtl/adfb_sqrt.sv
// adfb_sqrt: pipelined integer square root of a value scaled by 2**(2*FRAC_BITS)
// one result bit per register stage; depends on adfb_pkg
module adfb_sqrt #(
   parameter int IN_BITS   = 2 * adfb_pkg::COORD_BITS_DEF - 2,
   parameter int FRAC_BITS = adfb_pkg::SQRT_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [IN_BITS-1:0]             in_value,
   input  adfb_pkg::shade_side_type       in_side,
   output logic                           out_valid,
   output logic [IN_BITS/2+FRAC_BITS-1:0] out_root,
   output adfb_pkg::shade_side_type       out_side
);

   localparam int RB  = IN_BITS / 2 + FRAC_BITS;
   localparam int VW  = 2 * RB;
   localparam int RMW = RB + 2;

   logic                     valid_ff [RB];
   logic [RMW-1:0]           rem_ff   [RB];
   logic [RB-1:0]            q_ff     [RB];
   logic [VW-1:0]            v_ff     [RB];
   adfb_pkg::shade_side_type side_ff  [RB];

   genvar j;
   generate
      for (j = 0; j < RB; j++) begin : g_stage
         logic                     valid_p;
         logic [RMW-1:0]           rem_p;
         logic [RB-1:0]            q_p;
         logic [VW-1:0]            v_p;
         adfb_pkg::shade_side_type side_p;
         logic [RMW-1:0]           rem_t;
         logic [RMW-1:0]           trial;
         logic                     ge;
         logic [RMW-1:0]           rem_in;
         logic [RB-1:0]            q_in;

         if (j == 0) begin : g_first
            assign valid_p = in_valid;
            assign rem_p   = '0;
            assign q_p     = '0;
            assign v_p     = {in_value, {(2*FRAC_BITS){1'b0}}};
            assign side_p  = in_side;
         end else begin : g_next
            assign valid_p = valid_ff[j-1];
            assign rem_p   = rem_ff[j-1];
            assign q_p     = q_ff[j-1];
            assign v_p     = v_ff[j-1];
            assign side_p  = side_ff[j-1];
         end

         always_comb begin
            rem_t  = {rem_p[RMW-3:0], v_p[VW-1:VW-2]};
            trial  = {q_p, 2'b01};
            ge     = (rem_t >= trial);
            rem_in = ge ? (rem_t - trial) : rem_t;
            q_in   = {q_p[RB-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else begin
               valid_ff[j] <= valid_p;
            end
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            v_ff[j]    <= {v_p[VW-3:0], 2'b00};
            side_ff[j] <= side_p;
         end
      end
   endgenerate

   assign out_valid = valid_ff[RB-1];
   assign out_root  = q_ff[RB-1];
   assign out_side  = side_ff[RB-1];

endmodule

>>> rtl/adfb_blend.sv
// adfb_blend: pipelined non-premultiplied src-over blend with saturated channels
// restoring divide by the result alpha, one quotient bit per stage; depends on adfb_pkg
module adfb_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  adfb_pkg::blend_side_type        in_side,
   output logic                            out_valid,
   output logic [adfb_pkg::PIXEL_BITS-1:0] out_pixel,
   output logic                            out_touched
);

   localparam int NB = adfb_pkg::NUM_BITS;

   // stage 1: da * (255 - sa)
   logic                     v1_ff;
   adfb_pkg::blend_side_type side1_ff;
   logic [15:0]              t1_ff;

   // stage 2: result alpha and channel products
   logic                     v2_ff;
   adfb_pkg::blend_side_type side2_ff;
   logic [8:0]               a2_ff;
   logic [15:0]              pc2_ff [3];
   logic [23:0]              ct2_ff [3];

   // stage 3: channel numerators
   logic                     v3_ff;
   adfb_pkg::blend_side_type side3_ff;
   logic [8:0]               a3_ff;
   logic [NB-1:0]            num3_ff [3];

   // divider stages
   logic                     dv_ff   [NB];
   adfb_pkg::blend_side_type dside_ff[NB];
   logic [8:0]               da_ff   [NB];
   logic [NB-1:0]            dnum_ff [NB][3];
   logic [7:0]               drem_ff [NB][3];
   logic [NB-1:0]            dq_ff   [NB][3];

   logic                            out_valid_ff;
   logic [adfb_pkg::PIXEL_BITS-1:0] out_pixel_ff;
   logic                            out_touched_ff;

   logic [7:0]  sa1;
   logic [7:0]  da1;
   logic [7:0]  sa2;
   logic [40:0] pt2;
   logic [8:0]  a2_in;
   logic [7:0]  sa_f;
   logic [7:0]  fin_alpha;
   logic [adfb_pkg::PIXEL_BITS-1:0] pixel_in;

   always_comb begin
      sa1 = in_side.src[31:24];
      da1 = in_side.dst[31:24];
      sa2 = side1_ff.src[31:24];
      pt2 = 41'(t1_ff) * 41'(adfb_pkg::DIV255_MUL);
      a2_in = 9'(sa2) + 9'(pt2[40:adfb_pkg::DIV255_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      side1_ff <= in_side;
      t1_ff    <= 16'(da1) * 16'(adfb_pkg::ALPHA_MAX - sa1);
      side2_ff <= side1_ff;
      a2_ff    <= a2_in;
      side3_ff <= side2_ff;
      a3_ff    <= a2_ff;
   end

   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_chan
         logic [48:0] pq;
         assign pq = 49'(ct2_ff[c]) * 49'(adfb_pkg::DIV255_MUL);

         always_ff @(posedge clock) begin
            pc2_ff[c]  <= 16'(side1_ff.src[8*c +: 8]) * 16'(sa2);
            ct2_ff[c]  <= 24'(side1_ff.dst[8*c +: 8]) * 24'(t1_ff);
            num3_ff[c] <= NB'(pc2_ff[c]) + NB'(pq[47:adfb_pkg::DIV255_SHIFT]);
         end
      end
   endgenerate

   genvar j, k;
   generate
      for (j = 0; j < NB; j++) begin : g_div
         logic                     v_p;
         adfb_pkg::blend_side_type side_p;
         logic [8:0]               a_p;

         if (j == 0) begin : g_first
            assign v_p    = v3_ff;
            assign side_p = side3_ff;
            assign a_p    = a3_ff;
         end else begin : g_next
            assign v_p    = dv_ff[j-1];
            assign side_p = dside_ff[j-1];
            assign a_p    = da_ff[j-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[j] <= 1'b0;
            end else begin
               dv_ff[j] <= v_p;
            end
            dside_ff[j] <= side_p;
            da_ff[j]    <= a_p;
         end

         for (k = 0; k < 3; k++) begin : g_lane
            logic [NB-1:0] num_p;
            logic [7:0]    rem_p;
            logic [NB-1:0] q_p;
            logic [8:0]    rem_t;
            logic          ge;
            logic [8:0]    diff;

            if (j == 0) begin : g_first
               assign num_p = num3_ff[k];
               assign rem_p = '0;
               assign q_p   = '0;
            end else begin : g_next
               assign num_p = dnum_ff[j-1][k];
               assign rem_p = drem_ff[j-1][k];
               assign q_p   = dq_ff[j-1][k];
            end

            always_comb begin
               rem_t = {rem_p, num_p[NB-1]};
               ge    = (rem_t >= a_p);
               diff  = rem_t - a_p;
            end

            always_ff @(posedge clock) begin
               dnum_ff[j][k] <= {num_p[NB-2:0], 1'b0};
               drem_ff[j][k] <= ge ? diff[7:0] : rem_t[7:0];
               dq_ff[j][k]   <= {q_p[NB-2:0], ge};
            end
         end
      end
   endgenerate

   always_comb begin
      sa_f      = dside_ff[NB-1].src[31:24];
      fin_alpha = adfb_pkg::sat8(NB'(da_ff[NB-1]));
      if (!dside_ff[NB-1].touched) begin
         pixel_in = dside_ff[NB-1].dst;
      end else if (sa_f == adfb_pkg::ALPHA_MAX) begin
         pixel_in = dside_ff[NB-1].src;
      end else if (sa_f == 8'd0) begin
         pixel_in = dside_ff[NB-1].dst;
      end else if (da_ff[NB-1] == 9'd0) begin
         pixel_in = '0;
      end else begin
         pixel_in = {fin_alpha,
                     adfb_pkg::sat8(dq_ff[NB-1][2]),
                     adfb_pkg::sat8(dq_ff[NB-1][1]),
                     adfb_pkg::sat8(dq_ff[NB-1][0])};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_ff[NB-1];
      end
      out_pixel_ff   <= pixel_in;
      out_touched_ff <= dside_ff[NB-1].touched;
   end

   assign out_valid   = out_valid_ff;
   assign out_pixel   = out_pixel_ff;
   assign out_touched = out_touched_ff;

endmodule

>>> rtl/antialiased_disc_fill_blend_core.sv
// antialiased_disc_fill_blend_core: one pixel per clock, fully pipelined, never busy
// COORD_BITS + SQRT_FRAC_BITS + 26 register stages (46 at defaults): four for
// distance, one per square root bit, two for coverage, twenty-one for the blend
// (three for products, seventeen for the divider, one output register)
// rsp_valid pulses once per transaction; results cannot be held off by the receiver
// synchronous active-high reset clears the config registers and every valid bit
module antialiased_disc_fill_blend_core #(
   parameter int COORD_BITS     = adfb_pkg::COORD_BITS_DEF,
   parameter int SQRT_FRAC_BITS = adfb_pkg::SQRT_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [COORD_BITS-1:0]               req_pixel_x,
   input  logic [COORD_BITS-1:0]               req_pixel_y,
   input  logic [adfb_pkg::PIXEL_BITS-1:0]     req_dst_pixel,
   input  logic                                csr_we,
   input  logic [adfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adfb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                                rsp_valid,
   output logic [adfb_pkg::PIXEL_BITS-1:0]     rsp_out_pixel,
   output logic                                rsp_touched
);

   localparam int CB  = COORD_BITS + 1;
   localparam int RW  = COORD_BITS - 1;
   localparam int AW  = COORD_BITS + 1;
   localparam int SQW = 2 * AW;
   localparam int D2W = SQW + 1;
   localparam int R2W = 2 * RW;
   localparam int DB  = 2 * COORD_BITS - 2;
   localparam int RB  = DB / 2 + SQRT_FRAC_BITS;
   localparam int F   = SQRT_FRAC_BITS;
   localparam logic signed [RB+1:0] HALF_C = (RB+2)'(2 ** (F - 1));
   localparam logic signed [RB+1:0] ONE_C  = (RB+2)'(2 ** F);

   logic signed [CB-1:0] center_x_ff;
   logic signed [CB-1:0] center_y_ff;
   logic [RW-1:0]        radius_ff;
   logic [31:0]          fill_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         radius_ff     <= '0;
         fill_color_ff <= '0;
      end else if (csr_we) begin
         case (adfb_pkg::csr_index_type'(csr_index))
            adfb_pkg::CSR_CENTER_X:   center_x_ff   <= csr_wdata[CB-1:0];
            adfb_pkg::CSR_CENTER_Y:   center_y_ff   <= csr_wdata[CB-1:0];
            adfb_pkg::CSR_RADIUS:     radius_ff     <= csr_wdata[RW-1:0];
            adfb_pkg::CSR_FILL_COLOR: fill_color_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: absolute offsets
   logic signed [CB:0] dx_c;
   logic signed [CB:0] dy_c;
   logic [CB:0]        adx_c;
   logic [CB:0]        ady_c;

   always_comb begin
      dx_c  = $signed({2'b00, req_pixel_x}) - $signed({center_x_ff[CB-1], center_x_ff});
      dy_c  = $signed({2'b00, req_pixel_y}) - $signed({center_y_ff[CB-1], center_y_ff});
      adx_c = dx_c[CB] ? -dx_c : dx_c;
      ady_c = dy_c[CB] ? -dy_c : dy_c;
   end

   logic                            v1_ff, v2_ff, v3_ff, v4_ff;
   logic [adfb_pkg::PIXEL_BITS-1:0] dst1_ff, dst2_ff, dst3_ff;
   logic [AW-1:0]                   adx1_ff, ady1_ff;
   logic [SQW-1:0]                  sqx2_ff, sqy2_ff;
   logic [D2W-1:0]                  d2_3_ff;
   logic [DB-1:0]                   d2_4_ff;
   adfb_pkg::shade_side_type        side4_ff;

   // stage 4: disc and edge band tests
   logic [R2W-1:0] r2_c;
   logic [D2W-1:0] lo_c;
   logic [D2W-1:0] hi_c;
   logic           inside_c;
   logic           band_c;

   always_comb begin
      r2_c     = R2W'(radius_ff) * R2W'(radius_ff);
      lo_c     = D2W'(r2_c) - D2W'(radius_ff);
      hi_c     = D2W'(r2_c) + D2W'(radius_ff);
      inside_c = (radius_ff != '0) && (d2_3_ff <= lo_c);
      band_c   = (radius_ff != '0) && !inside_c && (d2_3_ff <= hi_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      dst1_ff          <= req_dst_pixel;
      adx1_ff          <= adx_c[AW-1:0];
      ady1_ff          <= ady_c[AW-1:0];
      dst2_ff          <= dst1_ff;
      sqx2_ff          <= SQW'(adx1_ff) * SQW'(adx1_ff);
      sqy2_ff          <= SQW'(ady1_ff) * SQW'(ady1_ff);
      dst3_ff          <= dst2_ff;
      d2_3_ff          <= D2W'(sqx2_ff) + D2W'(sqy2_ff);
      d2_4_ff          <= d2_3_ff[DB-1:0];
      side4_ff.dst     <= dst3_ff;
      side4_ff.in_disc <= inside_c;
      side4_ff.band    <= band_c;
   end

   logic                     sq_valid;
   logic [RB-1:0]            sq_root;
   adfb_pkg::shade_side_type sq_side;

   adfb_sqrt #(
      .IN_BITS   (DB),
      .FRAC_BITS (F)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_value  (d2_4_ff),
      .in_side   (side4_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage 5: coverage, clamped to one
   logic signed [RB+1:0] cov_c;
   logic [F:0]           covc_c;
   logic                 v5_ff;
   logic [F:0]           cov5_ff;
   logic                 pos5_ff;
   adfb_pkg::shade_side_type side5_ff;

   always_comb begin
      cov_c  = $signed({2'b00, radius_ff, {F{1'b0}}}) + HALF_C - $signed({2'b00, sq_root});
      covc_c = (cov_c > ONE_C) ? ONE_C[F:0] : cov_c[F:0];
   end

   // stage 6: scaled source alpha
   logic [8+F:0] sprod_c;
   logic [7:0]   alpha_c;
   logic         v6_ff;
   adfb_pkg::blend_side_type side6_ff;
   adfb_pkg::blend_side_type side6_in;

   always_comb begin
      sprod_c = (9+F)'(fill_color_ff[31:24]) * (9+F)'(cov5_ff);
      alpha_c = side5_ff.in_disc ? fill_color_ff[31:24]
                                 : adfb_pkg::sat8(adfb_pkg::NUM_BITS'(sprod_c[8+F:F]));
      side6_in.touched = side5_ff.in_disc || (side5_ff.band && pos5_ff);
      side6_in.dst     = side5_ff.dst;
      side6_in.src     = {alpha_c, fill_color_ff[23:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= sq_valid;
         v6_ff <= v5_ff;
      end
      cov5_ff  <= covc_c;
      pos5_ff  <= (cov_c > 0);
      side5_ff <= sq_side;
      side6_ff <= side6_in;
   end

   adfb_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v6_ff),
      .in_side     (side6_ff),
      .out_valid   (rsp_valid),
      .out_pixel   (rsp_out_pixel),
      .out_touched (rsp_touched)
   );

endmodule

>>> dv/antialiased_disc_fill_blend_core_tb.sv
`timescale 1ns / 100ps
// antialiased_disc_fill_blend_core_tb: self-checking bench for the disc fill shader core
// drives pixels and register writes from a queue, predicts each pixel, checks every result
// depends on adfb_pkg and antialiased_disc_fill_blend_core
module antialiased_disc_fill_blend_core_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 60;

   typedef enum logic [1:0] {
      ACT_PIXEL,
      ACT_CSR,
      ACT_DRAIN
   } action_kind_type;

   typedef struct {
      action_kind_type         kind;
      logic [11:0]             px;
      logic [11:0]             py;
      logic [31:0]             dst;
      adfb_pkg::csr_index_type idx;
      logic [31:0]             data;
   } action_type;

   typedef struct {
      logic [31:0] pixel;
      logic        touched;
   } shade_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [11:0]             req_pixel_x;
   logic [11:0]             req_pixel_y;
   logic [31:0]             req_dst_pixel;
   logic                    csr_we;
   adfb_pkg::csr_index_type csr_index;
   logic [31:0]             csr_wdata;
   logic                    rsp_valid;
   logic [31:0]             rsp_out_pixel;
   logic                    rsp_touched;

   action_type          pending_actions[$];
   shade_type           expected_shades[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  drain_wait;

   // shadow copy of the disc registers
   logic signed [12:0]  disc_cx;
   logic signed [12:0]  disc_cy;
   logic [10:0]         disc_radius;
   logic [31:0]         disc_fill;

   antialiased_disc_fill_blend_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .req_dst_pixel (req_dst_pixel),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_touched   (rsp_touched)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int unsigned clamp255(input int unsigned v);
      return (v > 255) ? 255 : v;
   endfunction

   function automatic logic [31:0] src_over(input logic [31:0] dst, input logic [31:0] src);
      int unsigned sa;
      int unsigned da;
      int unsigned a;
      int unsigned sc;
      int unsigned dc;
      int unsigned c;
      logic [31:0] res;
      sa = 32'(src[31:24]);
      da = 32'(dst[31:24]);
      if (sa == 255) return src;
      if (sa == 0) return dst;
      a = sa + (da * (255 - sa)) / 255;
      if (a == 0) return 32'd0;
      res = 32'd0;
      res[31:24] = 8'(clamp255(a));
      for (int sh = 0; sh < 24; sh += 8) begin
         sc = (src >> sh) & 8'hFF;
         dc = (dst >> sh) & 8'hFF;
         c = (sc * sa + (dc * da * (255 - sa)) / 255) / a;
         res = res | (clamp255(c) << sh);
      end
      return res;
   endfunction

   function automatic shade_type shade_pixel(input logic [11:0] px, input logic [11:0] py,
                                             input logic [31:0] dst);
      longint dx;
      longint dy;
      longint unsigned d2;
      longint unsigned r;
      longint unsigned s;
      longint cov;
      longint unsigned sa;
      shade_type res;
      dx = longint'(px) - longint'(disc_cx);
      dy = longint'(py) - longint'(disc_cy);
      d2 = dx * dx + dy * dy;
      r = 64'(disc_radius);
      res.pixel = dst;
      res.touched = 1'b0;
      if (r != 0) begin
         if (d2 <= r * r - r) begin
            res.pixel = src_over(dst, disc_fill);
            res.touched = 1'b1;
         end else if (d2 <= r * r + r) begin
            s = int_sqrt(d2 << 16);
            cov = longint'(r << 8) + 128 - longint'(s);
            if (cov > 256) cov = 256;
            if (cov > 0) begin
               sa = (longint'(disc_fill[31:24]) * cov) >> 8;
               res.pixel = src_over(dst, {8'(clamp255(int'(sa))), disc_fill[23:0]});
               res.touched = 1'b1;
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic add_pixel(input logic [11:0] px, input logic [11:0] py,
                            input logic [31:0] dst);
      action_type a;
      a.kind = ACT_PIXEL;
      a.px = px;
      a.py = py;
      a.dst = dst;
      a.idx = adfb_pkg::CSR_CENTER_X;
      a.data = '0;
      pending_actions.push_back(a);
   endtask

   task automatic add_csr(input adfb_pkg::csr_index_type idx, input logic [31:0] data);
      action_type a;
      a.kind = ACT_CSR;
      a.px = '0;
      a.py = '0;
      a.dst = '0;
      a.idx = idx;
      a.data = data;
      pending_actions.push_back(a);
   endtask

   task automatic add_drain();
      action_type a;
      a.kind = ACT_DRAIN;
      a.px = '0;
      a.py = '0;
      a.dst = '0;
      a.idx = adfb_pkg::CSR_CENTER_X;
      a.data = '0;
      pending_actions.push_back(a);
   endtask

   // drain, then rewrite all four registers; upper data bits carry noise
   task automatic add_disc(input int cx, input int cy, input int rad, input logic [31:0] fill);
      add_drain();
      add_csr(adfb_pkg::CSR_CENTER_X, {7'($urandom_range(0, 127)), 12'h0, 13'(cx)});
      add_csr(adfb_pkg::CSR_CENTER_Y, {19'($urandom), 13'(cy)});
      add_csr(adfb_pkg::CSR_RADIUS, {21'($urandom), 11'(rad)});
      add_csr(adfb_pkg::CSR_FILL_COLOR, fill);
   endtask

   function automatic logic [11:0] near_coord(input int c, input int rad);
      int lo;
      int hi;
      lo = c - rad - 2;
      hi = c + rad + 2;
      if (lo < 0) lo = 0;
      if (hi > 4095) hi = 4095;
      if (lo > hi) return 12'($urandom);
      return 12'($urandom_range(lo, hi));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         req_pixel_x <= '0;
         req_pixel_y <= '0;
         req_dst_pixel <= '0;
         csr_index <= adfb_pkg::CSR_CENTER_X;
         csr_wdata <= '0;
         disc_cx <= '0;
         disc_cy <= '0;
         disc_radius <= '0;
         disc_fill <= '0;
         drain_wait <= 0;
      end else if (!(start && busy)) begin
         if (start) expected_shades.push_back(shade_pixel(req_pixel_x, req_pixel_y,
                                                          req_dst_pixel));
         if (csr_we) begin
            case (csr_index)
               adfb_pkg::CSR_CENTER_X: disc_cx <= csr_wdata[12:0];
               adfb_pkg::CSR_CENTER_Y: disc_cy <= csr_wdata[12:0];
               adfb_pkg::CSR_RADIUS: disc_radius <= csr_wdata[10:0];
               adfb_pkg::CSR_FILL_COLOR: disc_fill <= csr_wdata;
               default: ;
            endcase
         end
         if (pending_actions.size() == 0) begin
            start <= 1'b0;
            csr_we <= 1'b0;
         end else if (pending_actions[0].kind == ACT_DRAIN) begin
            start <= 1'b0;
            csr_we <= 1'b0;
            if (expected_shades.size() != 0 || start) begin
               drain_wait <= 0;
            end else if (drain_wait < SETTLE_CYCLES) begin
               drain_wait <= drain_wait + 1;
            end else begin
               drain_wait <= 0;
               void'(pending_actions.pop_front());
            end
         end else if (pending_actions[0].kind == ACT_CSR) begin
            start <= 1'b0;
            csr_we <= 1'b1;
            csr_index <= pending_actions[0].idx;
            csr_wdata <= pending_actions[0].data;
            void'(pending_actions.pop_front());
         end else if ((cycle_count < 3000 || cycle_count > 6000)
                      && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            csr_we <= 1'b0;
         end else begin
            start <= 1'b1;
            csr_we <= 1'b0;
            req_pixel_x <= pending_actions[0].px;
            req_pixel_y <= pending_actions[0].py;
            req_dst_pixel <= pending_actions[0].dst;
            void'(pending_actions.pop_front());
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      shade_type want;
      if (!reset && rsp_valid) begin
         if (expected_shades.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_out_pixel, 32'd0);
         end else begin
            want = expected_shades.pop_front();
            if (rsp_out_pixel !== want.pixel)
               report_mismatch("out_pixel", rsp_out_pixel, want.pixel);
            if (rsp_touched !== want.touched)
               report_mismatch("touched", 32'(rsp_touched), 32'(want.touched));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("antialiased_disc_fill_blend_core test failed");
         $finish;
      end
   end

   initial begin
      int cx;
      int cy;
      int rad;
      int n;
      int pick;
      logic [31:0] fill;
      reset = 1'b1;

      // zero radius draws nothing
      add_pixel(12'd0, 12'd0, 32'hFFFFFFFF);
      add_pixel(12'hFFF, 12'hFFF, 32'h12345678);
      add_disc(100, 100, 10, 32'hFFFF0000);
      add_pixel(12'd100, 12'd100, 32'h00000000);
      add_pixel(12'd110, 12'd100, 32'h80808080);
      add_pixel(12'd107, 12'd107, 32'hFF00FF00);
      add_pixel(12'd111, 12'd100, 32'hFFFFFFFF);
      add_pixel(12'd150, 12'd150, 32'hA5A5A5A5);
      add_disc(100, 100, 10, 32'h8033CC77);
      add_pixel(12'd100, 12'd100, 32'h00000000);
      add_pixel(12'd100, 12'd100, 32'hFFFFFFFF);
      add_pixel(12'd100, 12'd110, 32'h40102030);
      add_pixel(12'd93, 12'd93, 32'hFF0000FF);
      add_disc(-4096, 4095, 2047, 32'h00FFFFFF);
      add_pixel(12'd0, 12'd4095, 32'h11223344);
      add_pixel(12'd0, 12'd2048, 32'h55667788);
      add_disc(4095, -4096, 1, 32'h01FFFFFF);
      add_pixel(12'd4095, 12'd0, 32'hFFFFFFFF);
      add_pixel(12'd4094, 12'd0, 32'h00000000);
      add_disc(0, 0, 2047, 32'hFF123456);
      add_pixel(12'd0, 12'd0, 32'h00FFFFFF);
      add_pixel(12'd1447, 12'd1447, 32'h80000000);

      for (int phase = 0; phase < 11; phase++) begin
         pick = $urandom_range(0, 9);
         cx = $urandom_range(0, 4095);
         cy = $urandom_range(0, 4095);
         if (pick == 0) rad = 0;
         else if (pick == 1) rad = 2047;
         else rad = $urandom_range(1, 40);
         if (phase == 3) begin
            cx = -4096;
            cy = 4095;
         end
         case ($urandom_range(0, 3))
            0: fill = {8'hFF, 24'($urandom)};
            1: fill = {8'h00, 24'($urandom)};
            default: fill = $urandom;
         endcase
         add_disc(cx, cy, rad, fill);
         n = $urandom_range(80, 110);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 80)
               add_pixel(near_coord(cx, rad), near_coord(cy, rad), $urandom);
            else
               add_pixel(12'($urandom), 12'($urandom), $urandom);
         end
      end
      add_drain();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_actions.size() != 0 || expected_shades.size() != 0 || start)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_shades.size() == 0)
         $display("antialiased_disc_fill_blend_core test passed");
      else
         $display("antialiased_disc_fill_blend_core test failed");
      $finish;
   end

endmodule
